[design/flow_sequence_rate_tracker_macros.svh]
// Assertion helpers used by flow_sequence_rate_tracker
`ifndef FLOW_SEQUENCE_RATE_TRACKER_MACROS_SVH
`define FLOW_SEQUENCE_RATE_TRACKER_MACROS_SVH
// implication checked every clock outside reset
`define FSRT_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication
`define FSRT_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

[design/fsrt_pkg.sv]
// ---------------------------------------------------------------------------
// fsrt_pkg
// Shared types and codes of the flow sequence rate tracker.
// ---------------------------------------------------------------------------
package fsrt_pkg;
   localparam logic [2:0] VERDICT_IN_ORDER = 3'd0;
   localparam logic [2:0] VERDICT_GAP      = 3'd1;
   localparam logic [2:0] VERDICT_DROP     = 3'd2;
   localparam logic [2:0] VERDICT_FULL     = 3'd3;
   localparam logic [2:0] VERDICT_BAD      = 3'd4;

   localparam logic [1:0] BP_NONE = 2'd0;
   localparam logic [1:0] BP_SLOW = 2'd1;
   localparam logic [1:0] BP_OK   = 2'd2;

   localparam logic [1:0] CSR_RATE_HIGH = 2'd0;
   localparam logic [1:0] CSR_RATE_LOW  = 2'd1;
   localparam logic [1:0] CSR_WINDOW    = 2'd2;

   localparam logic [15:0] RATE_HIGH_RESET = 16'd20;
   localparam logic [15:0] RATE_LOW_RESET  = 16'd10;

   typedef struct packed {
      logic [31:0] src_address;
      logic [15:0] src_port;
      logic        payload_ok;
      logic signed [31:0] seq_number;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [5:0]  flow_index;
      logic        new_flow;
      logic signed [31:0] expected_before;
      logic        window_closed;
      logic [15:0] measured_rate;
      logic [1:0]  backpressure_signal;
   } rsp_type;

   // per-flow state carried by one cell
   typedef struct packed {
      logic [31:0] address;
      logic [15:0] port;
      logic [31:0] next_seq;
      logic [15:0] packet_count;
      logic [31:0] win_start;
      logic        throttled;
   } entry_type;

   // control from the sequencer to every cell
   typedef struct packed {
      logic        write;
      logic [31:0] address;
      logic [15:0] port;
   } cell_ctrl_type;
endpackage

[design/fsrt_if.sv]
// ---------------------------------------------------------------------------
// fsrt_if
// Valid/ready channel carrying one word of a given payload type.
// ---------------------------------------------------------------------------
interface fsrt_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/flow_sequence_rate_tracker.sv]
// ---------------------------------------------------------------------------
// flow_sequence_rate_tracker
// Per-flow sequence check with a saturating rate window and hysteresis.
// ---------------------------------------------------------------------------
// channel | dir | word
// req     | in  | src_address, src_port, payload_ok, seq_number, now_seconds
// rsp     | out | verdict, flow_index, new_flow, expected_before, ...
// csr     | in  | write enable, index, 16-bit data
// Each word is captured while idle; in the update state the lookup through the
// cell chain and the read-modify-write of the hit cell are done. rsp is registered;
// a new req word is taken once the previous result is taken or being taken.
// Synchronous active-high reset empties the table; cell contents keep
// garbage until a slot is registered.
module flow_sequence_rate_tracker import fsrt_pkg::*; #(
   parameter int MAX_FLOWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   fsrt_if.sink        req,
   fsrt_if.source      rsp,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
`include "flow_sequence_rate_tracker_macros.svh"
   localparam int IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
   localparam int CNT_W = $clog2(MAX_FLOWS + 1);

   typedef enum logic {ST_IDLE, ST_UPDATE} state_type;

   state_type state_ff;
   logic [15:0] rate_high_ff, rate_low_ff;
   logic [7:0]  window_ff;
   logic [CNT_W-1:0] count_ff;
   req_type     req_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic [MAX_FLOWS:0]   hit;
   logic [IDX_W-1:0]     idx [MAX_FLOWS+1];
   entry_type            ent [MAX_FLOWS+1];
   logic [MAX_FLOWS-1:0] occ, sel;
   cell_ctrl_type        ctrl;
   entry_type            wr_entry;
   logic                 full, fresh;
   logic [IDX_W-1:0]     slot;
   entry_type            cur;
   rsp_type              rsp_in;

   assign hit[0] = 1'b0;
   assign idx[0] = '0;
   assign ent[0] = '0;

   for (genvar g = 0; g < MAX_FLOWS; g++) begin : g_cell
      assign occ[g] = CNT_W'(g) < count_ff;
      assign sel[g] = slot == IDX_W'(g);
      fsrt_cell #(.IDX_W(IDX_W)) u_cell (
         .clock, .occupied(occ[g]), .sel(sel[g]), .ctrl,
         .wr_entry, .hit_in(hit[g]), .idx_in(idx[g]), .ent_in(ent[g]),
         .my_idx(IDX_W'(g)), .hit_out(hit[g+1]), .idx_out(idx[g+1]),
         .ent_out(ent[g+1]));
   end

   assign req.ready = state_ff == ST_IDLE && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // key for the chain compare, write strobe for the selected cell
   assign ctrl = '{write: (state_ff == ST_UPDATE) && !full,
                   address: req_ff.src_address,
                   port: req_ff.src_port};

   // update step: chain result and entry build
   always_comb begin
      logic signed [31:0] s, e;
      logic [15:0] cnt;
      logic [31:0] el;
      cnt = '0;
      el = '0;
      s = req_ff.seq_number;
      fresh = !hit[MAX_FLOWS];
      full = fresh && count_ff == CNT_W'(MAX_FLOWS);
      slot = fresh ? count_ff[IDX_W-1:0] : idx[MAX_FLOWS];
      cur = ent[MAX_FLOWS];
      if (fresh) begin
         cur = '0;
         cur.address = req_ff.src_address;
         cur.port = req_ff.src_port;
         cur.win_start = req_ff.now_seconds;
      end
      e = cur.next_seq;
      wr_entry = cur;
      rsp_in = '0;
      rsp_in.flow_index = 6'(slot);
      rsp_in.new_flow = fresh;
      rsp_in.expected_before = e;
      if (full) begin
         rsp_in = '0;
         rsp_in.verdict = VERDICT_FULL;
      end else if (!req_ff.payload_ok) begin
         rsp_in.verdict = VERDICT_BAD;
      end else if (s < e) begin
         rsp_in.verdict = VERDICT_DROP;
      end else begin
         rsp_in.verdict = (s > e) ? VERDICT_GAP : VERDICT_IN_ORDER;
         wr_entry.next_seq = s + 32'sd1;
         cnt = (cur.packet_count == 16'hFFFF) ? cur.packet_count
                                             : cur.packet_count + 16'd1;
         wr_entry.packet_count = cnt;
         el = req_ff.now_seconds - cur.win_start;
         if (el >= {24'd0, window_ff}) begin
            wr_entry.packet_count = '0;
            wr_entry.win_start = req_ff.now_seconds;
            rsp_in.window_closed = 1'b1;
            rsp_in.measured_rate = cnt;
            if (cnt > rate_high_ff && !cur.throttled) begin
               rsp_in.backpressure_signal = BP_SLOW;
               wr_entry.throttled = 1'b1;
            end else if (cnt <= rate_low_ff && cur.throttled) begin
               rsp_in.backpressure_signal = BP_OK;
               wr_entry.throttled = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         rate_high_ff <= RATE_HIGH_RESET;
         rate_low_ff <= RATE_LOW_RESET;
         window_ff <= 8'd1;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_RATE_HIGH: rate_high_ff <= csr_data;
               CSR_RATE_LOW:  rate_low_ff <= csr_data;
               CSR_WINDOW:    window_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  req_ff <= req.payload;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               rsp_ff <= rsp_in;
               rsp_valid_ff <= 1'b1;
               if (fresh && !full) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `FSRT_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_FLOWS), "count over table size")
   `FSRT_ASSERT_NEXT(a_update_done, clock, reset, state_ff == ST_UPDATE, rsp_valid_ff && state_ff == ST_IDLE, "update did not post result")
   `FSRT_ASSERT_IMPL(a_full_no_write, clock, reset, full && state_ff == ST_UPDATE, !ctrl.write, "full table written")
endmodule

[design/fsrt_cell.sv]
// ---------------------------------------------------------------------------
// fsrt_cell
// One flow slot: compares its key and passes the first hit down the chain.
// ---------------------------------------------------------------------------
module fsrt_cell import fsrt_pkg::*; #(
   parameter int IDX_W = 6
) (
   input  logic                clock,
   input  logic                occupied,
   input  logic                sel,
   input  cell_ctrl_type       ctrl,
   input  entry_type           wr_entry,
   input  logic                hit_in,
   input  logic [IDX_W-1:0]    idx_in,
   input  entry_type           ent_in,
   input  logic [IDX_W-1:0]    my_idx,
   output logic                hit_out,
   output logic [IDX_W-1:0]    idx_out,
   output entry_type           ent_out
);
   entry_type entry_ff;
   logic match;

   assign match = occupied && entry_ff.address == ctrl.address &&
                  entry_ff.port == ctrl.port;
   assign hit_out = hit_in | match;
   assign idx_out = hit_in ? idx_in : my_idx;
   assign ent_out = hit_in ? ent_in : entry_ff;

   always_ff @(posedge clock) begin
      if (ctrl.write && sel) begin
         entry_ff <= wr_entry;
      end
   end
endmodule
